@@ sv/dkspt_pkg.sv @@
// Shared types and constants of the dual-key sorted point table.
// No dependencies; every other file imports this package.
package dkspt_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ_X = 2'd1,
    CMD_READ_Y = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_POINT = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } req_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               last;
    logic               dropped;
  } res_t;

  typedef struct packed {
    logic insert;
    logic emit_empty;
    logic rd_begin;
    logic rd_sel_y;
    logic rd_emit;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;
  } stat_t;

endpackage

@@ sv/dkspt_ctrl.sv @@
// Controller state machine of the dual-key sorted point table.
// Depends on dkspt_pkg; drives the datapath through ctrl_t and reads stat_t.
module dkspt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [1:0]      cmd_i,
  input  dkspt_pkg::stat_t stat_i,
  output dkspt_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import dkspt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q == ST_READ);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i == CMD_INSERT) begin
            ctrl_o.insert = 1'b1;
          end else if (cmd_i == CMD_READ_X || cmd_i == CMD_READ_Y) begin
            if (stat_i.empty) begin
              ctrl_o.emit_empty = 1'b1;
            end else begin
              ctrl_o.rd_begin = 1'b1;
              ctrl_o.rd_sel_y = (cmd_i == CMD_READ_Y);
              state_d         = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        ctrl_o.rd_emit = 1'b1;
        if (stat_i.rd_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/dkspt_datapath.sv @@
// Datapath of the dual-key sorted point table: two sorted cell chains,
// the entry count, the read index and the result register. Depends on dkspt_pkg.
module dkspt_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dkspt_pkg::req_t  req_i,
  input  dkspt_pkg::ctrl_t ctrl_i,
  output dkspt_pkg::stat_t stat_o,
  output logic             res_valid_o,
  output dkspt_pkg::res_t  res_o
);
  import dkspt_pkg::*;

  logic [63:0]     x_st_q [CAPACITY];
  logic [63:0]     y_st_q [CAPACITY];
  logic [63:0]     x_st_d [CAPACITY];
  logic [63:0]     y_st_d [CAPACITY];
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            sel_y_q, sel_y_d;
  logic            res_valid_q, res_valid_d;
  res_t            res_q, res_d;
  logic [CAPACITY-1:0] x_lt, y_lt;
  logic [63:0]     new_entry;
  logic [63:0]     rd_entry;
  logic            do_store;

  assign new_entry = {req_i.x_value, req_i.y_value};
  assign do_store  = ctrl_i.insert && !stat_o.full;

  assign stat_o.full    = (count_q == CntW'(CAPACITY));
  assign stat_o.empty   = (count_q == '0);
  assign stat_o.rd_last = ((CntW'(rd_idx_q) + CntW'(1)) == count_q);

  // Every cell whose key is smaller than the new key keeps its point; the first
  // cell that is not takes the new point and all cells after it shift up.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      x_lt[i] = (CntW'(i) < count_q) &&
                ($signed(req_i.x_value) > $signed(x_st_q[i][63:32]));
      y_lt[i] = (CntW'(i) < count_q) &&
                ($signed(req_i.y_value) > $signed(y_st_q[i][31:0]));
    end
    x_st_d[0] = x_lt[0] ? x_st_q[0] : new_entry;
    y_st_d[0] = y_lt[0] ? y_st_q[0] : new_entry;
    for (int i = 1; i < CAPACITY; i++) begin
      if (x_lt[i]) begin
        x_st_d[i] = x_st_q[i];
      end else if (x_lt[i-1]) begin
        x_st_d[i] = new_entry;
      end else begin
        x_st_d[i] = x_st_q[i-1];
      end
      if (y_lt[i]) begin
        y_st_d[i] = y_st_q[i];
      end else if (y_lt[i-1]) begin
        y_st_d[i] = new_entry;
      end else begin
        y_st_d[i] = y_st_q[i-1];
      end
    end
  end

  assign rd_entry = sel_y_q ? y_st_q[rd_idx_q] : x_st_q[rd_idx_q];

  always_comb begin
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    sel_y_d     = sel_y_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    if (ctrl_i.insert) begin
      res_valid_d   = 1'b1;
      res_d.kind    = KIND_ACK;
      res_d.last    = 1'b1;
      res_d.dropped = stat_o.full;
      if (do_store) begin
        count_d = count_q + CntW'(1);
      end
    end
    if (ctrl_i.emit_empty) begin
      res_valid_d = 1'b1;
      res_d.kind  = KIND_EMPTY;
      res_d.last  = 1'b1;
    end
    if (ctrl_i.rd_begin) begin
      rd_idx_d = '0;
      sel_y_d  = ctrl_i.rd_sel_y;
    end
    if (ctrl_i.rd_emit) begin
      res_valid_d   = 1'b1;
      res_d.kind    = KIND_POINT;
      res_d.point_x = rd_entry[63:32];
      res_d.point_y = rd_entry[31:0];
      res_d.last    = stat_o.rd_last;
      rd_idx_d      = rd_idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rd_idx_q    <= '0;
      sel_y_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rd_idx_q    <= rd_idx_d;
      sel_y_q     <= sel_y_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (do_store) begin
      for (int i = 0; i < CAPACITY; i++) begin
        x_st_q[i] <= x_st_d[i];
        y_st_q[i] <= y_st_d[i];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/dual_key_sorted_point_table.sv @@
// Top level of the dual-key sorted point table.
// Depends on dkspt_pkg, dkspt_ctrl and dkspt_datapath.
//
// A request beat is taken at a rising edge with start_i high and busy_o low.
// Command insert stores the point in both the x order and the y order; its
// acknowledgement appears in the cycle after the request, with dropped set when
// the table already held CAPACITY points. Commands read x and read y emit
// every stored point in that order, one result per cycle; the first result is
// registered in the read state, and the last beat has last set. An empty table
// answers a read with a single empty result. Command value 3 is ignored.
// Each result beat is shown for exactly one cycle with res_valid_o high; the
// receiver cannot stall, so the output register never holds a beat longer.
// An insert or an empty read does not hold off the next request; during a
// read busy_o stays high while the read index walks the stored entries, and a
// new request is taken in the cycle the final point is shown.
// Reset clears the entry count, so the table is empty afterwards; the cell
// contents are not cleared.
module dual_key_sorted_point_table (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  dkspt_pkg::req_t req_i,
  output logic            busy_o,
  output logic            res_valid_o,
  output dkspt_pkg::res_t res_o
);
  import dkspt_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  dkspt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (req_i.cmd),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy_o)
  );

  dkspt_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
